[rtl/assert_macros.svh]
// Assertion macros used by the top level of the slot allocator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every clock edge outside reset.
`define SFQ_ASSERT(lbl, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("assertion failed");

// Implication checked at every clock edge outside reset.
`define SFQ_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`endif

[rtl/sfq_pkg.sv]
// Package with the types and constants of the slot allocator.
`default_nettype none
package sfq_pkg;

    localparam int SLOTS_DEF = 64;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_REMOVE = 1'b1;

    localparam logic [1:0] ST_STORED    = 2'd0;
    localparam logic [1:0] ST_REMOVED   = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_POP_WAIT,
        S_POP_CHK,
        S_APPEND,
        S_SEARCH,
        S_SHRINK
    } t_state;

    typedef struct packed {
        logic        command;
        logic [31:0] handle;
    } t_req;

    typedef struct packed {
        logic [5:0] slot_index;
        logic [1:0] status;
        logic [6:0] live_count;
    } t_res;

    typedef struct packed {
        logic wr;
        logic clr;
        logic run;
    } t_cell_ctl;

endpackage
`default_nettype wire

[rtl/sfq_cell.sv]
// One slot of the table: stored handle, valid bit and the search token stage.
`default_nettype none
module sfq_cell (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire sfq_pkg::t_cell_ctl i_ctl,
    input  wire logic [31:0]       i_key,
    input  wire logic              i_token,
    output logic                   o_token,
    output logic                   o_valid,
    output logic                   o_hit
);
    logic        r_valid;
    logic        r_token;
    logic [31:0] r_handle;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_token <= 1'b0;
        end else begin
            r_token <= i_token & i_ctl.run;
            if (i_ctl.wr) begin
                r_valid <= 1'b1;
            end else if (i_ctl.clr) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr) begin
            r_handle <= i_key;
        end
    end

    assign o_token = r_token;
    assign o_valid = r_valid;
    assign o_hit   = r_token & r_valid & (r_handle == i_key);
endmodule
`default_nettype wire

[rtl/sfq_queue.sv]
// FIFO of freed slot indices held in a memory with a registered read port.
`default_nettype none
module sfq_queue #(
    parameter int SLOTS = sfq_pkg::SLOTS_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_push,
    input  wire logic [$clog2(SLOTS)-1:0]   i_push_idx,
    input  wire logic                       i_pop,
    output logic      [$clog2(SLOTS)-1:0]   o_head_data,
    output logic      [$clog2(SLOTS+1)-1:0] o_fill
);
    localparam int IW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);

    logic [IW-1:0] r_mem [SLOTS];
    logic [IW-1:0] r_head;
    logic [IW-1:0] r_tail;
    logic [CW-1:0] r_fill;
    logic [IW-1:0] r_rdata;
    logic          s_push_ok;

    // A freed index that finds the queue full is dropped.
    assign s_push_ok = i_push && (r_fill != CW'(SLOTS));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_tail <= '0;
            r_fill <= '0;
        end else begin
            if (s_push_ok) begin
                r_tail <= (r_tail == IW'(SLOTS - 1)) ? '0 : r_tail + 1'b1;
                r_fill <= r_fill + 1'b1;
            end else if (i_pop) begin
                r_head <= (r_head == IW'(SLOTS - 1)) ? '0 : r_head + 1'b1;
                r_fill <= r_fill - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_push_ok) begin
            r_mem[r_tail] <= i_push_idx;
        end
        r_rdata <= r_mem[r_head];
    end

    assign o_head_data = r_rdata;
    assign o_fill      = r_fill;
endmodule
`default_nettype wire

[rtl/slot_allocator_free_queue_top.sv]
// Top level of the slot allocator with a queue of freed slot indices.
//
// A request is taken when i_start is high and o_busy is low; i_req carries
// the command (insert or remove) and the 32-bit handle. Each request gives
// exactly one result on o_res, shown for one cycle with o_done high; the
// receiver cannot stall, so it must take the result in that cycle.
// An insert pops queued indices one at a time (one memory read wait state
// and one check state each), and uses an append state when the queue is
// empty or no popped index is usable.
// A remove passes a token down the row of slot cells, one cell per cycle,
// until it finds the handle or has checked the last slot; when the last slot
// in use is removed, a walk back over trailing empty slots follows. The
// result is registered and appears the cycle after the last step. After
// reset all slots are empty, the queue is empty and the live count is zero;
// no clearing pass is needed.
`default_nettype none
`include "assert_macros.svh"
module slot_allocator_free_queue_top #(
    parameter int SLOTS = sfq_pkg::SLOTS_DEF
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_start,
    input  wire sfq_pkg::t_req i_req,
    output logic              o_busy,
    output logic              o_done,
    output sfq_pkg::t_res     o_res
);
    localparam int IW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);

    sfq_pkg::t_state r_state, n_state;
    logic [31:0]     r_handle;
    logic [IW-1:0]   r_k, n_k;
    logic [IW-1:0]   r_idx, n_idx;
    logic [CW-1:0]   r_used, n_used;
    logic            r_done, n_done;
    sfq_pkg::t_res   r_res, n_res;

    logic            s_accept;
    logic            s_wr;
    logic [IW-1:0]   s_wr_idx;
    logic            s_clr;
    logic            s_run;
    logic            s_pop;
    logic            s_push;
    logic            s_hit;
    logic            s_last;
    logic [IW-1:0]   s_q_data;
    logic [CW-1:0]   s_q_fill;

    logic [SLOTS-1:0] s_valid;
    logic [SLOTS-1:0] s_hit_vec;
    logic [SLOTS:0]   s_token;

    assign s_accept = i_start && (r_state == sfq_pkg::S_IDLE);
    assign s_hit    = |s_hit_vec;
    assign s_last   = (r_k == IW'(SLOTS - 1));
    assign s_token[0] = s_accept && (i_req.command == sfq_pkg::CMD_REMOVE);

    genvar gi;
    generate
        for (gi = 0; gi < SLOTS; gi++) begin : g_cell
            sfq_pkg::t_cell_ctl s_ctl;
            assign s_ctl.wr  = s_wr && (s_wr_idx == IW'(gi));
            assign s_ctl.clr = s_clr && (r_k == IW'(gi));
            assign s_ctl.run = s_run;
            sfq_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctl   (s_ctl),
                .i_key   (r_handle),
                .i_token (s_token[gi]),
                .o_token (s_token[gi+1]),
                .o_valid (s_valid[gi]),
                .o_hit   (s_hit_vec[gi])
            );
        end
    endgenerate

    sfq_queue #(.SLOTS(SLOTS)) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (s_push),
        .i_push_idx  (r_k),
        .i_pop       (s_pop),
        .o_head_data (s_q_data),
        .o_fill      (s_q_fill)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sfq_pkg::S_IDLE: begin
                if (s_accept) begin
                    if (i_req.command == sfq_pkg::CMD_REMOVE) begin
                        n_state = sfq_pkg::S_SEARCH;
                    end else if (s_q_fill != '0) begin
                        n_state = sfq_pkg::S_POP_WAIT;
                    end else begin
                        n_state = sfq_pkg::S_APPEND;
                    end
                end
            end
            sfq_pkg::S_POP_WAIT: begin
                n_state = sfq_pkg::S_POP_CHK;
            end
            sfq_pkg::S_POP_CHK: begin
                if (CW'(s_q_data) < r_used) begin
                    n_state = sfq_pkg::S_IDLE;
                end else if (s_q_fill == CW'(1)) begin
                    n_state = sfq_pkg::S_APPEND;
                end else begin
                    n_state = sfq_pkg::S_POP_WAIT;
                end
            end
            sfq_pkg::S_APPEND: begin
                n_state = sfq_pkg::S_IDLE;
            end
            sfq_pkg::S_SEARCH: begin
                if (s_hit) begin
                    n_state = (CW'(r_k) + 1'b1 == r_used) ? sfq_pkg::S_SHRINK
                                                          : sfq_pkg::S_IDLE;
                end else if (s_last) begin
                    n_state = sfq_pkg::S_IDLE;
                end
            end
            sfq_pkg::S_SHRINK: begin
                if (s_valid[r_k] || (r_k == '0)) begin
                    n_state = sfq_pkg::S_IDLE;
                end
            end
            default: n_state = sfq_pkg::S_IDLE;
        endcase
    end

    // Outputs and datapath control.
    always_comb begin
        s_wr     = 1'b0;
        s_wr_idx = r_k;
        s_clr    = 1'b0;
        s_run    = 1'b0;
        s_pop    = 1'b0;
        s_push   = 1'b0;
        n_k      = r_k;
        n_idx    = r_idx;
        n_used   = r_used;
        n_done   = 1'b0;
        n_res    = r_res;
        unique case (r_state)
            sfq_pkg::S_IDLE: begin
                if (s_accept) begin
                    n_k   = '0;
                    s_run = (i_req.command == sfq_pkg::CMD_REMOVE);
                end
            end
            sfq_pkg::S_POP_WAIT: begin
            end
            sfq_pkg::S_POP_CHK: begin
                s_pop = 1'b1;
                if (CW'(s_q_data) < r_used) begin
                    s_wr     = 1'b1;
                    s_wr_idx = s_q_data;
                    n_done   = 1'b1;
                    n_res    = '{slot_index: 6'(s_q_data), status: sfq_pkg::ST_STORED,
                                 live_count: 7'(r_used)};
                end
            end
            sfq_pkg::S_APPEND: begin
                n_done = 1'b1;
                if (r_used == CW'(SLOTS)) begin
                    n_res = '{slot_index: 6'd0, status: sfq_pkg::ST_FULL,
                              live_count: 7'(r_used)};
                end else begin
                    s_wr     = 1'b1;
                    s_wr_idx = IW'(r_used);
                    n_used   = r_used + 1'b1;
                    n_res    = '{slot_index: 6'(r_used), status: sfq_pkg::ST_STORED,
                                 live_count: 7'(n_used)};
                end
            end
            sfq_pkg::S_SEARCH: begin
                if (s_hit) begin
                    s_clr = 1'b1;
                    n_idx = r_k;
                    if (CW'(r_k) + 1'b1 != r_used) begin
                        s_push = 1'b1;
                        n_done = 1'b1;
                        n_res  = '{slot_index: 6'(r_k), status: sfq_pkg::ST_REMOVED,
                                   live_count: 7'(r_used)};
                    end
                end else if (s_last) begin
                    n_done = 1'b1;
                    n_res  = '{slot_index: 6'd0, status: sfq_pkg::ST_NOT_FOUND,
                               live_count: 7'(r_used)};
                end else begin
                    s_run = 1'b1;
                    n_k   = r_k + 1'b1;
                end
            end
            sfq_pkg::S_SHRINK: begin
                // Walk back over trailing empty slots, one per cycle.
                if (!s_valid[r_k]) begin
                    if (r_k == '0) begin
                        n_used = '0;
                    end else begin
                        n_used = CW'(r_k);
                        n_k    = r_k - 1'b1;
                    end
                end
                if (s_valid[r_k] || (r_k == '0)) begin
                    n_done = 1'b1;
                    n_res  = '{slot_index: 6'(r_idx), status: sfq_pkg::ST_REMOVED,
                               live_count: 7'(n_used)};
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sfq_pkg::S_IDLE;
            r_used  <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_used  <= n_used;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_k   <= n_k;
        r_idx <= n_idx;
        r_res <= n_res;
        if (s_accept) begin
            r_handle <= i_req.handle;
        end
    end

    assign o_busy = (r_state != sfq_pkg::S_IDLE);
    assign o_done = r_done;
    assign o_res  = r_res;

    `SFQ_ASSERT(a_token_single, $onehot0(s_token[SLOTS-1:0]))
    `SFQ_ASSERT_IMP(a_done_idle, r_done, r_state == sfq_pkg::S_IDLE)
    `SFQ_ASSERT_IMP(a_token_search, |s_token[SLOTS:1], r_state == sfq_pkg::S_SEARCH)
    `SFQ_ASSERT(a_used_range, r_used <= CW'(SLOTS))
endmodule
`default_nettype wire
